### design/lphs_pkg.sv
`default_nettype none

package lphs_pkg;

   // fixed field widths
   localparam int KEY_W = 64;
   localparam int CFG_W = 11;

   // default key limit after reset
   localparam logic [CFG_W-1:0] MAX_KEYS_RESET = 11'd768;

   // request codes
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // slot states
   localparam logic [1:0] SLOT_EMPTY    = 2'd0;
   localparam logic [1:0] SLOT_DELETED  = 2'd1;
   localparam logic [1:0] SLOT_OCCUPIED = 2'd2;

   // multiplicative hash constant, split in halves for the 32x32 multiplier
   localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
   localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [KEY_W-1:0] key;
   } lphs_req_type;

   typedef struct packed {
      logic             success;
      logic             table_full;
      logic [CFG_W-1:0] stored_count;
   } lphs_rsp_type;

   typedef struct packed {
      logic hash_start;
      logic clear_wr;
      logic set_home;
      logic advance;
      logic note_free;
      logic wr_insert;
      logic wr_delete;
      logic set_result;
      logic res_success;
      logic res_full;
      logic emit;
   } lphs_cmd_type;

   typedef struct packed {
      logic hash_done;
      logic slot_empty;
      logic slot_occupied;
      logic key_match;
      logic last_probe;
      logic have_free;
      logic at_limit;
      logic out_busy;
   } lphs_sts_type;

endpackage

`default_nettype wire

### design/lphs_hash.sv
`default_nettype none

module lphs_hash #(
   parameter int TABLE_SIZE = 1024,
   parameter int KEY_BITS   = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [KEY_BITS-1:0]           key,
   output logic                               done,
   output logic [$clog2(TABLE_SIZE)-1:0]      home
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
   localparam logic [IDX_W:0] MOD_M = (IDX_W + 1)'(TABLE_SIZE);
   localparam int DIGITS = 64 / 4;

   localparam logic [2:0] H_IDLE = 3'd0;
   localparam logic [2:0] H_M0   = 3'd1;
   localparam logic [2:0] H_M1   = 3'd2;
   localparam logic [2:0] H_M2   = 3'd3;
   localparam logic [2:0] H_ADD  = 3'd4;
   localparam logic [2:0] H_MIX  = 3'd5;
   localparam logic [2:0] H_MOD  = 3'd6;

   logic [2:0]       state_ff;
   logic [2:0]       state_in;
   logic [63:0]      k_ff;
   logic [63:0]      prod_ff;
   logic [63:0]      acc_ff;
   logic [63:0]      x_ff;
   logic [IDX_W-1:0] rem_ff;
   logic [3:0]       digit_ff;
   logic             done_ff;
   logic [IDX_W-1:0] home_ff;
   logic [31:0]      mul_a;
   logic [31:0]      mul_b;
   logic [63:0]      mul_p;
   logic [IDX_W:0]   rem_step;
   logic [IDX_W-1:0] rem_in;

   // one shared 32x32 multiplier, low 64 bits of the product built over three passes
   assign mul_a = (state_ff == H_M2) ? k_ff[63:32] : k_ff[31:0];
   assign mul_b = (state_ff == H_M1) ? lphs_pkg::HASH_MUL_HI : lphs_pkg::HASH_MUL_LO;
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // four restoring remainder steps per cycle, msb first
   always_comb begin
      rem_step = {1'b0, rem_ff};
      for (int j = 0; j < 4; j++) begin
         rem_step = {rem_step[IDX_W-1:0], x_ff[63-j]};
         if (rem_step >= MOD_M) begin
            rem_step = rem_step - MOD_M;
         end
      end
      rem_in = rem_step[IDX_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               state_in = H_M0;
            end
         end
         H_M0:  state_in = H_M1;
         H_M1:  state_in = H_M2;
         H_M2:  state_in = H_ADD;
         H_ADD: state_in = H_MIX;
         H_MIX: state_in = H_MOD;
         H_MOD: begin
            if (IS_POW2 || digit_ff == 4'(DIGITS - 1)) begin
               state_in = H_IDLE;
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == H_MOD) && (state_in == H_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == H_IDLE && start) begin
         k_ff <= 64'(key);
      end
      prod_ff <= mul_p;
      if (state_ff == H_M1) begin
         acc_ff <= prod_ff;
      end else if (state_ff == H_M2 || state_ff == H_ADD) begin
         acc_ff <= acc_ff + {prod_ff[31:0], 32'd0};
      end
      if (state_ff == H_MIX) begin
         x_ff     <= acc_ff ^ {32'd0, acc_ff[63:32]};
         rem_ff   <= '0;
         digit_ff <= '0;
      end else if (state_ff == H_MOD) begin
         x_ff     <= {x_ff[59:0], 4'd0};
         rem_ff   <= rem_in;
         digit_ff <= digit_ff + 4'd1;
         home_ff  <= IS_POW2 ? x_ff[IDX_W-1:0] : rem_in;
      end
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule

`default_nettype wire

### design/lphs_ctrl.sv
`default_nettype none

module lphs_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [1:0]             req_op,
   output logic                        req_stall,
   input  wire lphs_pkg::lphs_sts_type sts,
   output lphs_pkg::lphs_cmd_type      cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [1:0] op_ff;
   logic       stop_probe;
   logic       free_avail;

   assign req_stall  = (state_ff != S_IDLE);
   assign stop_probe = sts.slot_empty || sts.last_probe;
   assign free_avail = sts.have_free || !sts.slot_occupied;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.advance  = 1'b1;
            if (sts.last_probe) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == lphs_pkg::OP_NONE) begin
                  cmd.set_result = 1'b1;
                  state_in       = S_DONE;
               end else begin
                  cmd.hash_start = 1'b1;
                  state_in       = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (sts.hash_done) begin
               cmd.set_home = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (op_ff == lphs_pkg::OP_INSERT) begin
               if (sts.slot_occupied && sts.key_match) begin
                  // duplicate: refused, not full
                  cmd.set_result = 1'b1;
                  state_in       = S_DONE;
               end else if (stop_probe) begin
                  cmd.set_result = 1'b1;
                  if (free_avail && !sts.at_limit) begin
                     cmd.wr_insert   = 1'b1;
                     cmd.res_success = 1'b1;
                  end else begin
                     cmd.res_full = 1'b1;
                  end
                  state_in = S_DONE;
               end else begin
                  cmd.note_free = !sts.slot_occupied;
                  cmd.advance   = 1'b1;
                  state_in      = S_READ;
               end
            end else begin
               if (sts.slot_empty) begin
                  cmd.set_result = 1'b1;
                  state_in       = S_DONE;
               end else if (sts.slot_occupied && sts.key_match) begin
                  cmd.wr_delete   = (op_ff == lphs_pkg::OP_REMOVE);
                  cmd.set_result  = 1'b1;
                  cmd.res_success = 1'b1;
                  state_in        = S_DONE;
               end else if (sts.last_probe) begin
                  cmd.set_result = 1'b1;
                  state_in       = S_DONE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         S_DONE: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         op_ff <= req_op;
      end
   end

`ifndef SYNTH
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !sts.out_busy)
      else $error("result emitted while output register still holds a stalled beat");

   a_insert_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_insert |-> (!sts.at_limit && (sts.have_free || !sts.slot_occupied)))
      else $error("insert written past key limit or without a free slot");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_insert && cmd.wr_delete) && !(cmd.clear_wr && (cmd.wr_insert || cmd.wr_delete)))
      else $error("conflicting table writes");

   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_HASH || state_ff == S_DONE))
      else $error("accepted beat did not start work");
`endif

endmodule

`default_nettype wire

### design/lphs_dp.sv
`default_nettype none

module lphs_dp #(
   parameter int TABLE_SIZE = 1024,
   parameter int KEY_BITS   = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire lphs_pkg::lphs_req_type               req_data,
   input  wire logic                                 csr_wr_en,
   input  wire logic [lphs_pkg::CFG_W-1:0]           csr_wr_data,
   input  wire lphs_pkg::lphs_cmd_type               cmd,
   output lphs_pkg::lphs_sts_type                    sts,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output lphs_pkg::lphs_rsp_type                    rsp_data
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int CNT_W = $clog2(TABLE_SIZE + 1);
   localparam int CMP_W = (CNT_W > lphs_pkg::CFG_W) ? CNT_W : lphs_pkg::CFG_W;
   localparam int WORD_W = KEY_BITS + 2;

   logic [WORD_W-1:0]         slot_mem [TABLE_SIZE];
   logic [WORD_W-1:0]         rd_ff;
   logic [KEY_BITS-1:0]       key_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W-1:0]          idx_next;
   logic [IDX_W-1:0]          probe_ff;
   logic                      have_free_ff;
   logic [IDX_W-1:0]          free_idx_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [lphs_pkg::CFG_W-1:0] max_keys_ff;
   logic                      res_success_ff;
   logic                      res_full_ff;
   logic                      rsp_valid_ff;
   lphs_pkg::lphs_rsp_type    rsp_data_ff;
   logic [CMP_W-1:0]          count_wide;
   logic                      hash_done;
   logic [IDX_W-1:0]          hash_home;
   logic                      mem_we;
   logic [IDX_W-1:0]          wr_addr;
   logic [1:0]                wr_state;
   logic [1:0]                rd_state;

   lphs_hash #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_BITS   (KEY_BITS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (cmd.hash_start),
      .key   (req_data.key[KEY_BITS-1:0]),
      .done  (hash_done),
      .home  (hash_home)
   );

   assign idx_next   = (idx_ff == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_ff + IDX_W'(1);
   assign count_wide = CMP_W'(count_ff);
   assign rd_state   = rd_ff[WORD_W-1:KEY_BITS];

   // insert lands on the first tombstone passed, else on the current slot
   assign mem_we   = cmd.clear_wr || cmd.wr_insert || cmd.wr_delete;
   assign wr_addr  = (cmd.wr_insert && have_free_ff) ? free_idx_ff : idx_ff;
   assign wr_state = cmd.wr_insert ? lphs_pkg::SLOT_OCCUPIED :
                     cmd.wr_delete ? lphs_pkg::SLOT_DELETED : lphs_pkg::SLOT_EMPTY;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[wr_addr] <= {wr_state, key_ff};
      end
      rd_ff <= slot_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.hash_start) begin
         key_ff <= req_data.key[KEY_BITS-1:0];
      end
      if (cmd.note_free && !have_free_ff) begin
         free_idx_ff <= idx_ff;
      end
      if (cmd.set_result) begin
         res_success_ff <= cmd.res_success;
         res_full_ff    <= cmd.res_full;
      end
      if (cmd.emit) begin
         rsp_data_ff.success      <= res_success_ff;
         rsp_data_ff.table_full   <= res_full_ff;
         rsp_data_ff.stored_count <= count_wide[lphs_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         probe_ff     <= '0;
         have_free_ff <= 1'b0;
         count_ff     <= '0;
         max_keys_ff  <= lphs_pkg::MAX_KEYS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.set_home) begin
            idx_ff       <= hash_home;
            probe_ff     <= '0;
            have_free_ff <= 1'b0;
         end else if (cmd.advance) begin
            idx_ff   <= idx_next;
            probe_ff <= probe_ff + IDX_W'(1);
         end
         if (cmd.note_free) begin
            have_free_ff <= 1'b1;
         end
         if (cmd.wr_insert) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.wr_delete && count_ff != '0) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (csr_wr_en) begin
            max_keys_ff <= csr_wr_data;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.hash_done     = hash_done;
   assign sts.slot_empty    = (rd_state == lphs_pkg::SLOT_EMPTY);
   assign sts.slot_occupied = (rd_state == lphs_pkg::SLOT_OCCUPIED);
   assign sts.key_match     = (rd_ff[KEY_BITS-1:0] == key_ff);
   assign sts.last_probe    = (probe_ff == IDX_W'(TABLE_SIZE - 1));
   assign sts.have_free     = have_free_ff;
   assign sts.at_limit      = (count_wide >= CMP_W'(max_keys_ff));
   assign sts.out_busy      = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_SIZE))
      else $error("stored key count above table size");
`endif

endmodule

`default_nettype wire

### design/linear_probing_hash_set_unit.sv
`default_nettype none

// hash set of fixed-width keys, open addressing with linear probing and
// tombstones. each request beat carries an operation (lookup, insert,
// remove; the fourth code does nothing) and a key, of which the low
// KEY_BITS bits take part. the key is hashed (multiply by the golden-ratio
// constant mod 2^64, fold the high half onto the low half, take it mod
// TABLE_SIZE) to a home slot, then slots are probed one after another with
// wraparound. lookup and remove stop at an empty slot and skip tombstones;
// insert refuses duplicates, reuses the first tombstone passed, and reports
// table_full when no free slot exists or the stored count has reached the
// csr key limit (reset 768). every request gives exactly one response beat
// with the stored count after the request. requests are handled one at a
// time: the hash runs on a shared 32x32 multiplier (with remainder steps
// added when TABLE_SIZE is not a power of two), and each probed slot takes
// a registered table read and then a decision. the response sits in an
// output register, so the next request is taken while a finished beat
// still waits. after reset the block clears the slot-state table and
// stalls requests meanwhile; csr writes are taken at any time but are
// meant for idle periods only.
module linear_probing_hash_set_unit #(
   parameter int TABLE_SIZE = 1024,
   parameter int KEY_BITS   = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire lphs_pkg::lphs_req_type        req_data,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output lphs_pkg::lphs_rsp_type             rsp_data,
   // key limit register
   input  wire logic                          csr_wr_en,
   input  wire logic [lphs_pkg::CFG_W-1:0]    csr_wr_data
);

   // command and status between sequencer and datapath
   lphs_pkg::lphs_cmd_type cmd;
   lphs_pkg::lphs_sts_type sts;

   // sequencer: clearing pass, hash wait, probe loop, response hand-off
   lphs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: hash unit, slot table, probe index, count, output register
   lphs_dp #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_BITS   (KEY_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
